// ----- rtl/dsf_pkg.sv -----
// ----------------------------------------------------------------------------
// dsf_pkg
// Shared types and constants of the duplicate sequence-number filter.
// ----------------------------------------------------------------------------
package dsf_pkg;

  localparam int SRC_W = 16;
  localparam int SEQ_W = 8;

  localparam logic REQ_CHECK    = 1'b0;
  localparam logic REQ_REGISTER = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the incoming request
    logic commit;  // evaluate the held request, update cells, load result
  } dsf_cmd_t;

endpackage

// ----- rtl/dsf_in_if.sv -----
// ----------------------------------------------------------------------------
// dsf_in_if
// Request channel: valid/ready handshake with request type, sender, seqno.
// ----------------------------------------------------------------------------
interface dsf_in_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [dsf_pkg::SRC_W-1:0] src_address;
  logic [dsf_pkg::SEQ_W-1:0] seq_number;

  modport source (output valid, output req_type, output src_address,
                  output seq_number, input ready);
  modport sink   (input valid, input req_type, input src_address,
                  input seq_number, output ready);
endinterface

// ----- rtl/dsf_out_if.sv -----
// ----------------------------------------------------------------------------
// dsf_out_if
// Result channel: valid/ready handshake with the duplicate flag.
// ----------------------------------------------------------------------------
interface dsf_out_if;
  logic valid;
  logic ready;
  logic is_duplicate;

  modport source (output valid, output is_duplicate, input ready);
  modport sink   (input valid, input is_duplicate, output ready);
endinterface

// ----- rtl/dsf_ctrl.sv -----
// ----------------------------------------------------------------------------
// dsf_ctrl
// Controller: tracks a held request and the output register, issues
// load and commit commands to the datapath.
// ----------------------------------------------------------------------------
module dsf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output dsf_pkg::dsf_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic commit;
  logic load;

  // Commit when the output register is free or drains this cycle
  assign commit   = (state_r == ST_EXEC) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == ST_IDLE) || commit;
  assign load     = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (load) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (commit && !load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign cmd.load   = load;
  assign cmd.commit = commit;

endmodule

// ----- rtl/dsf_datapath.sv -----
// ----------------------------------------------------------------------------
// dsf_datapath
// Request register, row of MRU cells with per-cell compare and shift,
// and the result register.
// ----------------------------------------------------------------------------
module dsf_datapath #(
  parameter int TABLE_DEPTH = 16,
  parameter int ADDR_BITS   = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dsf_pkg::dsf_cmd_t         cmd,
  input  logic                      req_type,
  input  logic [dsf_pkg::SRC_W-1:0] src_address,
  input  logic [dsf_pkg::SEQ_W-1:0] seq_number,
  output logic                      is_duplicate
);

  localparam int KEY_W = (ADDR_BITS < dsf_pkg::SRC_W) ? ADDR_BITS : dsf_pkg::SRC_W;

  logic                      req_type_r;
  logic [KEY_W-1:0]          req_key_r;
  logic [dsf_pkg::SEQ_W-1:0] req_seq_r;

  logic [KEY_W-1:0]          cell_key_r [TABLE_DEPTH];
  logic [dsf_pkg::SEQ_W-1:0] cell_seq_r [TABLE_DEPTH];

  logic [TABLE_DEPTH-1:0] key_hit;
  logic [TABLE_DEPTH-1:0] seq_eq;
  logic [TABLE_DEPTH-1:0] hit_ahead;   // some cell in front of this one matches
  logic [TABLE_DEPTH-1:0] first_hit;
  logic                   do_insert;
  logic                   dup_nxt;
  logic                   dup_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r <= req_type;
      req_key_r  <= src_address[KEY_W-1:0];
      req_seq_r  <= seq_number;
    end
  end

  genvar k;
  generate
    for (k = 0; k < TABLE_DEPTH; k++) begin : g_cmp
      assign key_hit[k] = (cell_key_r[k] == req_key_r);
      assign seq_eq[k]  = (cell_seq_r[k] == req_seq_r);
      if (k == 0) begin : g_front
        assign hit_ahead[k] = 1'b0;
      end else begin : g_rest
        assign hit_ahead[k] = |key_hit[k-1:0];
      end
      assign first_hit[k] = key_hit[k] && !hit_ahead[k];
    end
  endgenerate

  assign do_insert = cmd.commit && (req_type_r == dsf_pkg::REQ_REGISTER);
  assign dup_nxt   = (req_type_r == dsf_pkg::REQ_CHECK) && |(first_hit & seq_eq);

  // Insert puts the pair in cell 0; a cell moves back while no match sits ahead
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        cell_key_r[i] <= '0;
        cell_seq_r[i] <= '0;
      end
    end else if (do_insert) begin
      cell_key_r[0] <= req_key_r;
      cell_seq_r[0] <= req_seq_r;
      for (int i = 1; i < TABLE_DEPTH; i++) begin
        if (!hit_ahead[i]) begin
          cell_key_r[i] <= cell_key_r[i-1];
          cell_seq_r[i] <= cell_seq_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      dup_r <= dup_nxt;
    end
  end

  assign is_duplicate = dup_r;

endmodule

// ----- rtl/duplicate_seqno_filter.sv -----
// ----------------------------------------------------------------------------
// duplicate_seqno_filter
// Duplicate sequence-number filter over a most-recently-used list of
// (sender address, last sequence number) cells.
//
// in_chan carries requests: req_type selects a duplicate check or a
// registration, src_address (low ADDR_BITS bits compared) and seq_number.
// out_chan returns one is_duplicate flag per request, in order; it is
// always 0 for a registration.
// A request waits in the request register until it commits. At commit all
// cells compare in parallel, the list shifts on a registration, and the
// result enters the output register at the end of that cycle. A request
// passes the request register, then the output register, before its result
// is valid; one request per cycle is sustained while results are taken.
// If the receiver stalls, the result waits in the output register; one more
// request is accepted and held, then in_chan.ready drops until room returns.
// Reset (synchronous, rst_n low) clears every cell to address 0 and
// sequence 0 and empties the pipeline; requests are taken once rst_n is released.
// ----------------------------------------------------------------------------
module duplicate_seqno_filter #(
  parameter int TABLE_DEPTH = 16,
  parameter int ADDR_BITS   = 16
) (
  input logic      clk,
  input logic      rst_n,
  dsf_in_if.sink   in_chan,
  dsf_out_if.source out_chan
);

  dsf_pkg::dsf_cmd_t cmd;

  dsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  dsf_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_BITS   (ADDR_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .req_type     (in_chan.req_type),
    .src_address  (in_chan.src_address),
    .seq_number   (in_chan.seq_number),
    .is_duplicate (out_chan.is_duplicate)
  );

endmodule
